### rtl/covering_tuple_count_engine_defines.svh
// Assertion macros for the covering tuple count engine.
`ifndef COVERING_TUPLE_COUNT_ENGINE_DEFINES_SVH
`define COVERING_TUPLE_COUNT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define CTC_CHECK_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctc check failed");
`define CTC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctc check failed");
`else
`define CTC_CHECK_IMPLY(label, ante, cons)
`define CTC_CHECK_NEXT(label, ante, cons)
`endif
`endif

### rtl/ctc_pkg.sv
// Shared constants, codes and helper functions of the tuple count engine.
`default_nettype none
package ctc_pkg;
  localparam int ROWS     = 64;
  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NTRIPLES = 35;
  localparam int NPATS    = 27;
  localparam int NPAIRS   = NTRIPLES * NPATS;
  localparam int PAIR_AW  = $clog2(NPAIRS);
  localparam logic [PAIR_AW-1:0] PAIR_LAST = PAIR_AW'(NPAIRS - 1);
  localparam logic [PAIR_AW-1:0] UNC_RESET = PAIR_AW'(NPAIRS);
  localparam logic [5:0] TRIPLE_LAST = 6'(NTRIPLES - 1);
  localparam logic [4:0] PAT_LAST    = 5'(NPATS - 1);
  localparam logic [6:0] CNT_MAX     = 7'd127;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_STORE = 3'd1;
  localparam logic [2:0] ACT_EVAL  = 3'd2;
  localparam logic [2:0] ACT_APPLY = 3'd3;
  localparam logic [2:0] ACT_FIND  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROW  = 2'd1;
  localparam logic [1:0] ST_NO_PAIR = 2'd2;

  localparam logic [1:0] REG_W_UNCOV = 2'd0;
  localparam logic [1:0] REG_W_ONCE  = 2'd1;
  localparam logic [1:0] REG_W_TWICE = 2'd2;

  localparam logic [15:0] W_UNCOV_RST = 16'd10000;
  localparam logic [15:0] W_ONCE_RST  = 16'd20;
  localparam logic [15:0] W_TWICE_RST = 16'd2;

  // columns i, j, k of each triple, one octal digit each
  localparam logic [8:0] TRIPLE_COLS [NTRIPLES] = '{
    9'o012, 9'o013, 9'o014, 9'o015, 9'o016, 9'o023, 9'o024, 9'o025, 9'o026,
    9'o034, 9'o035, 9'o036, 9'o045, 9'o046, 9'o056,
    9'o123, 9'o124, 9'o125, 9'o126, 9'o134, 9'o135, 9'o136, 9'o145, 9'o146,
    9'o156,
    9'o234, 9'o235, 9'o236, 9'o245, 9'o246, 9'o256,
    9'o345, 9'o346, 9'o356,
    9'o456
  };

  typedef logic [13:0] row_t;

  function automatic logic [1:0] sat_cell(logic [1:0] c);
    return (c == 2'd3) ? 2'd2 : c;
  endfunction

  function automatic logic [4:0] pattern_of(row_t row, logic [5:0] t);
    logic [8:0] cols;
    logic [4:0] a, b, c;
    cols = TRIPLE_COLS[t];
    a = {3'b0, row[{cols[8:6], 1'b0} +: 2]};
    b = {3'b0, row[{cols[5:3], 1'b0} +: 2]};
    c = {3'b0, row[{cols[2:0], 1'b0} +: 2]};
    return (a << 3) + a + (b << 1) + b + c;
  endfunction

  function automatic row_t force_row(row_t row, logic [5:0] t, logic [4:0] p);
    logic [8:0] cols;
    logic [1:0] d0, d1, d2;
    logic [4:0] r0;
    row_t res;
    cols = TRIPLE_COLS[t];
    d0 = (p >= 5'd18) ? 2'd2 : ((p >= 5'd9) ? 2'd1 : 2'd0);
    r0 = p - ({3'b0, d0} << 3) - {3'b0, d0};
    d1 = (r0 >= 5'd6) ? 2'd2 : ((r0 >= 5'd3) ? 2'd1 : 2'd0);
    d2 = 2'(r0 - ({3'b0, d1} << 1) - {3'b0, d1});
    res = row;
    res[{cols[8:6], 1'b0} +: 2] = d0;
    res[{cols[5:3], 1'b0} +: 2] = d1;
    res[{cols[2:0], 1'b0} +: 2] = d2;
    return res;
  endfunction

  function automatic logic [PAIR_AW-1:0] pair_addr(logic [5:0] t, logic [4:0] p);
    logic [PAIR_AW-1:0] tw;
    tw = PAIR_AW'(t);
    return (tw << 4) + (tw << 3) + (tw << 1) + tw + PAIR_AW'(p);
  endfunction

  function automatic logic [15:0] weight_sel(logic [6:0] c, logic [15:0] wu,
                                             logic [15:0] w1, logic [15:0] w2);
    logic [15:0] w;
    unique case (c)
      7'd0:    w = wu;
      7'd1:    w = w1;
      7'd2:    w = w2;
      default: w = 16'd0;
    endcase
    return w;
  endfunction
endpackage
`default_nettype wire

### rtl/ctc_in_if.sv
// Input transaction channel of the tuple count engine.
`default_nettype none
interface ctc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [5:0] row_index;
  logic [1:0] cell_zero;
  logic [1:0] cell_one;
  logic [1:0] cell_two;
  logic [1:0] cell_three;
  logic [1:0] cell_four;
  logic [1:0] cell_five;
  logic [1:0] cell_six;
  logic [5:0] target_triple;
  logic [4:0] target_pattern;
  logic [9:0] ordinal;
  modport source (output valid, action, row_index, cell_zero, cell_one, cell_two,
                  cell_three, cell_four, cell_five, cell_six, target_triple,
                  target_pattern, ordinal, input ready);
  modport sink (input valid, action, row_index, cell_zero, cell_one, cell_two,
                cell_three, cell_four, cell_five, cell_six, target_triple,
                target_pattern, ordinal, output ready);
endinterface
`default_nettype wire

### rtl/ctc_out_if.sv
// Result transaction channel of the tuple count engine.
`default_nettype none
interface ctc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [6:0]  delta_uncovered;
  logic signed [23:0] delta_energy;
  logic [9:0]         uncovered_count;
  logic [5:0]         found_triple;
  logic [4:0]         found_pattern;
  modport source (output valid, status, delta_uncovered, delta_energy,
                  uncovered_count, found_triple, found_pattern, input ready);
  modport sink (input valid, status, delta_uncovered, delta_energy,
                uncovered_count, found_triple, found_pattern, output ready);
endinterface
`default_nettype wire

### rtl/ctc_cfg_if.sv
// Configuration write channel of the tuple count engine.
`default_nettype none
interface ctc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/covering_tuple_count_engine.sv
// Top level: strength-3 covering array tuple counter with search actions.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+--------------------------------------------
//  in_ch   | in  | valid/ready | action, row, seven cells, triple, pattern, ordinal
//  out_ch  | out | valid/ready | status, deltas, uncovered count, found pair
//  cfg_ch  | in  | valid/ready | register index, 16-bit weight (always ready)
//
// Pace: the count RAM has one write and one registered read port. Store reads
// the old row, then reads and writes one count per triple; when it replaces a
// present row it runs a removal pass and then an add pass. Evaluate reads the old
// and forced pattern counts of each triple; apply also writes both back when they
// differ. Find scans the RAM one entry a cycle. Clear is a zeroing sweep of the
// count RAM; after reset the same sweep runs with in_ch.ready low. One transaction
// in flight; a finished result waits in the output register while the next is taken.
`default_nettype none
`include "covering_tuple_count_engine_defines.svh"
module covering_tuple_count_engine (
  input wire logic clk,
  input wire logic rst_n,
  ctc_in_if.sink   in_ch,
  ctc_out_if.source out_ch,
  ctc_cfg_if.sink  cfg_ch
);
  localparam int RAW = ctc_pkg::ROW_AW;
  localparam int PAW = ctc_pkg::PAIR_AW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ROWRD, S_URD, S_UWR, S_TRD0, S_TRD1, S_TCALC, S_TWR,
    S_FIND, S_DONE
  } state_t;

  state_t state_r;

  // weights
  logic [15:0] w_uncov_r, w_once_r, w_twice_r;

  // transaction fields
  logic [2:0]           act_r;
  logic [RAW-1:0]       row_r;
  logic [5:0]           tt_r;
  logic [4:0]           tp_r;
  logic [9:0]           ord_r;
  ctc_pkg::row_t        old_row_r, new_row_r, upd_row_r;
  logic                 upd_add_r, upd_more_r;
  logic [5:0]           t_r;
  logic [6:0]           co_r, cn_r;
  logic [PAW-1:0]       clr_addr_r;
  logic                 clr_resp_r;
  logic [PAW-1:0]       unc_r;
  logic [ctc_pkg::ROWS-1:0] present_r;

  // find scan
  logic [PAW-1:0] scan_a_r;
  logic [5:0]     scan_t_r, dly_t_r;
  logic [4:0]     scan_p_r, dly_p_r;
  logic           dly_v_r;
  logic [9:0]     seen_r;

  // pending result
  logic [1:0]         res_status_r;
  logic signed [6:0]  res_dm_r;
  logic signed [23:0] res_de_r;
  logic [5:0]         res_ft_r;
  logic [4:0]         res_fp_r;

  // output register
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [6:0]  out_dm_r;
  logic signed [23:0] out_de_r;
  logic [9:0]         out_unc_r;
  logic [5:0]         out_ft_r;
  logic [4:0]         out_fp_r;

  // RAM ports
  logic           cnt_we;
  logic [PAW-1:0] cnt_waddr, cnt_raddr;
  logic [6:0]     cnt_wdata, cnt_rdata;
  logic           row_we;
  ctc_pkg::row_t  row_wdata, row_rdata;

  logic [4:0]     oi_pat, ni_pat, up_pat;
  logic [PAW-1:0] oi_addr, ni_addr, up_addr;
  ctc_pkg::row_t  forced_row, in_row;
  logic           in_acc, row_ok, last_t, out_free, same_pat;
  logic [6:0]     upd_cnt, co_dec, cn_inc;
  logic signed [6:0]  dm_term;
  logic [23:0]        de_term;
  logic [15:0]        w_com1, w_co, w_cn, w_cnp1;
  logic [5:0]         in_tt;
  logic [4:0]         in_tp;

  ctc_ram #(.WIDTH(7), .DEPTH(ctc_pkg::NPAIRS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata_r(cnt_rdata)
  );

  ctc_ram #(.WIDTH(14), .DEPTH(ctc_pkg::ROWS)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_r), .wdata(row_wdata),
    .raddr(in_ch.row_index[RAW-1:0]), .rdata_r(row_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign row_ok   = {1'b0, in_ch.row_index} < 7'(ctc_pkg::ROWS);
  assign last_t   = (t_r == ctc_pkg::TRIPLE_LAST);
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_tt = (in_ch.target_triple > ctc_pkg::TRIPLE_LAST) ? ctc_pkg::TRIPLE_LAST
                                                              : in_ch.target_triple;
  assign in_tp = (in_ch.target_pattern > ctc_pkg::PAT_LAST) ? ctc_pkg::PAT_LAST
                                                            : in_ch.target_pattern;
  assign in_row = {ctc_pkg::sat_cell(in_ch.cell_six), ctc_pkg::sat_cell(in_ch.cell_five),
                   ctc_pkg::sat_cell(in_ch.cell_four), ctc_pkg::sat_cell(in_ch.cell_three),
                   ctc_pkg::sat_cell(in_ch.cell_two), ctc_pkg::sat_cell(in_ch.cell_one),
                   ctc_pkg::sat_cell(in_ch.cell_zero)};

  // patterns of the current triple in the old, forced and updated rows
  assign oi_pat  = ctc_pkg::pattern_of(old_row_r, t_r);
  assign ni_pat  = ctc_pkg::pattern_of(new_row_r, t_r);
  assign up_pat  = ctc_pkg::pattern_of(upd_row_r, t_r);
  assign oi_addr = ctc_pkg::pair_addr(t_r, oi_pat);
  assign ni_addr = ctc_pkg::pair_addr(t_r, ni_pat);
  assign up_addr = ctc_pkg::pair_addr(t_r, up_pat);
  assign same_pat = (oi_pat == ni_pat);
  assign forced_row = ctc_pkg::force_row(row_rdata, tt_r, tp_r);

  // count after one row update, saturating at both ends
  assign upd_cnt = upd_add_r ? ((cnt_rdata < ctc_pkg::CNT_MAX) ? cnt_rdata + 7'd1 : cnt_rdata)
                             : ((cnt_rdata != 7'd0) ? cnt_rdata - 7'd1 : cnt_rdata);
  assign co_dec  = (co_r != 7'd0) ? co_r - 7'd1 : co_r;
  assign cn_inc  = (cn_r < ctc_pkg::CNT_MAX) ? cn_r + 7'd1 : cn_r;

  // energy and coverage change of one triple; cn is on the RAM output in S_TCALC
  always_comb begin
    w_co   = ctc_pkg::weight_sel(co_r, w_uncov_r, w_once_r, w_twice_r);
    w_cn   = ctc_pkg::weight_sel(cnt_rdata, w_uncov_r, w_once_r, w_twice_r);
    w_com1 = (co_r == 7'd0) ? 16'd0
           : ctc_pkg::weight_sel(co_r - 7'd1, w_uncov_r, w_once_r, w_twice_r);
    w_cnp1 = (cnt_rdata == ctc_pkg::CNT_MAX) ? 16'd0
           : ctc_pkg::weight_sel(cnt_rdata + 7'd1, w_uncov_r, w_once_r, w_twice_r);
    de_term = {8'd0, w_com1} - {8'd0, w_co} + {8'd0, w_cnp1} - {8'd0, w_cn};
    dm_term = 7'((co_r == 7'd1) ? 1 : 0) - 7'((co_r == 7'd0) ? 1 : 0)
            - 7'((cnt_rdata == 7'd0) ? 1 : 0);
  end

  // count RAM port muxing
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr_r;
    cnt_wdata = 7'd0;
    cnt_raddr = '0;
    unique case (state_r)
      S_CLR: begin
        cnt_we = 1'b1;
      end
      S_URD: begin
        cnt_raddr = up_addr;
      end
      S_UWR: begin
        cnt_we    = 1'b1;
        cnt_waddr = up_addr;
        cnt_wdata = upd_cnt;
      end
      S_TRD0: begin
        cnt_raddr = oi_addr;
      end
      S_TRD1: begin
        cnt_raddr = ni_addr;
      end
      S_TCALC: begin
        cnt_we    = (act_r == ctc_pkg::ACT_APPLY) && !same_pat;
        cnt_waddr = oi_addr;
        cnt_wdata = co_dec;
      end
      S_TWR: begin
        cnt_we    = 1'b1;
        cnt_waddr = ni_addr;
        cnt_wdata = cn_inc;
      end
      S_FIND: begin
        cnt_raddr = (scan_a_r <= ctc_pkg::PAIR_LAST) ? scan_a_r : '0;
      end
      default: begin
      end
    endcase
  end

  assign row_we    = (state_r == S_ROWRD) &&
                     (act_r == ctc_pkg::ACT_STORE || act_r == ctc_pkg::ACT_APPLY);
  assign row_wdata = (act_r == ctc_pkg::ACT_STORE) ? new_row_r : forced_row;

  // weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_uncov_r <= ctc_pkg::W_UNCOV_RST;
      w_once_r  <= ctc_pkg::W_ONCE_RST;
      w_twice_r <= ctc_pkg::W_TWICE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ctc_pkg::REG_W_UNCOV: w_uncov_r <= cfg_ch.data;
        ctc_pkg::REG_W_ONCE:  w_once_r  <= cfg_ch.data;
        ctc_pkg::REG_W_TWICE: w_twice_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_resp_r  <= 1'b0;
      present_r   <= '0;
      unc_r       <= ctc_pkg::UNC_RESET;
      out_valid_r <= 1'b0;
      dly_v_r     <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ctc_pkg::PAIR_LAST) begin
            unc_r   <= ctc_pkg::UNC_RESET;
            state_r <= clr_resp_r ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            act_r        <= in_ch.action;
            row_r        <= in_ch.row_index[RAW-1:0];
            tt_r         <= in_tt;
            tp_r         <= in_tp;
            ord_r        <= in_ch.ordinal;
            new_row_r    <= in_row;
            res_status_r <= ctc_pkg::ST_OK;
            res_dm_r     <= '0;
            res_de_r     <= '0;
            res_ft_r     <= '0;
            res_fp_r     <= '0;
            t_r          <= '0;
            unique case (in_ch.action)
              ctc_pkg::ACT_CLEAR: begin
                present_r  <= '0;
                clr_addr_r <= '0;
                clr_resp_r <= 1'b1;
                state_r    <= S_CLR;
              end
              ctc_pkg::ACT_STORE: begin
                if (row_ok) begin
                  state_r <= S_ROWRD;
                end else begin
                  res_status_r <= ctc_pkg::ST_NO_ROW;
                  state_r      <= S_DONE;
                end
              end
              ctc_pkg::ACT_EVAL, ctc_pkg::ACT_APPLY: begin
                if (row_ok && present_r[in_ch.row_index[RAW-1:0]]) begin
                  state_r <= S_ROWRD;
                end else begin
                  res_status_r <= ctc_pkg::ST_NO_ROW;
                  state_r      <= S_DONE;
                end
              end
              ctc_pkg::ACT_FIND: begin
                if (in_ch.ordinal >= unc_r) begin
                  res_status_r <= ctc_pkg::ST_NO_PAIR;
                  state_r      <= S_DONE;
                end else begin
                  scan_a_r <= '0;
                  scan_t_r <= '0;
                  scan_p_r <= '0;
                  dly_v_r  <= 1'b0;
                  seen_r   <= '0;
                  state_r  <= S_FIND;
                end
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end

        S_ROWRD: begin
          old_row_r <= row_rdata;
          if (act_r == ctc_pkg::ACT_STORE) begin
            present_r[row_r] <= 1'b1;
            if (present_r[row_r]) begin
              // remove the old row first, then add the new one
              upd_row_r  <= row_rdata;
              upd_add_r  <= 1'b0;
              upd_more_r <= 1'b1;
            end else begin
              upd_row_r  <= new_row_r;
              upd_add_r  <= 1'b1;
              upd_more_r <= 1'b0;
            end
            state_r <= S_URD;
          end else begin
            new_row_r <= forced_row;
            state_r   <= S_TRD0;
          end
        end

        S_URD: begin
          state_r <= S_UWR;
        end

        S_UWR: begin
          if (upd_add_r && cnt_rdata == 7'd0) begin
            unc_r <= unc_r - 1'b1;
          end else if (!upd_add_r && cnt_rdata == 7'd1) begin
            unc_r <= unc_r + 1'b1;
          end
          if (last_t) begin
            if (upd_more_r) begin
              upd_row_r  <= new_row_r;
              upd_add_r  <= 1'b1;
              upd_more_r <= 1'b0;
              t_r        <= '0;
              state_r    <= S_URD;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            t_r     <= t_r + 1'b1;
            state_r <= S_URD;
          end
        end

        S_TRD0: begin
          state_r <= S_TRD1;
        end

        S_TRD1: begin
          co_r    <= cnt_rdata;
          state_r <= S_TCALC;
        end

        S_TCALC: begin
          cn_r <= cnt_rdata;
          if (!same_pat) begin
            res_dm_r <= res_dm_r + dm_term;
            res_de_r <= res_de_r + de_term;
          end
          if (!same_pat && act_r == ctc_pkg::ACT_APPLY) begin
            if (co_r == 7'd1) begin
              unc_r <= unc_r + 1'b1;
            end
            state_r <= S_TWR;
          end else if (last_t) begin
            state_r <= S_DONE;
          end else begin
            t_r     <= t_r + 1'b1;
            state_r <= S_TRD0;
          end
        end

        S_TWR: begin
          if (cn_r == 7'd0) begin
            unc_r <= unc_r - 1'b1;
          end
          if (last_t) begin
            state_r <= S_DONE;
          end else begin
            t_r     <= t_r + 1'b1;
            state_r <= S_TRD0;
          end
        end

        S_FIND: begin
          // issue one address a cycle, check the entry whose address was issued in the previous cycle
          dly_v_r <= (scan_a_r <= ctc_pkg::PAIR_LAST);
          dly_t_r <= scan_t_r;
          dly_p_r <= scan_p_r;
          if (scan_a_r <= ctc_pkg::PAIR_LAST) begin
            scan_a_r <= scan_a_r + 1'b1;
            if (scan_p_r == ctc_pkg::PAT_LAST) begin
              scan_p_r <= '0;
              scan_t_r <= scan_t_r + 1'b1;
            end else begin
              scan_p_r <= scan_p_r + 1'b1;
            end
          end
          if (dly_v_r && cnt_rdata == 7'd0) begin
            if (seen_r == ord_r) begin
              res_ft_r <= dly_t_r;
              res_fp_r <= dly_p_r;
              state_r  <= S_DONE;
            end else begin
              seen_r <= seen_r + 1'b1;
            end
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_dm_r     <= res_dm_r;
            out_de_r     <= res_de_r;
            out_unc_r    <= unc_r;
            out_ft_r     <= res_ft_r;
            out_fp_r     <= res_fp_r;
            clr_resp_r   <= 1'b0;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.delta_uncovered = out_dm_r;
  assign out_ch.delta_energy    = out_de_r;
  assign out_ch.uncovered_count = out_unc_r;
  assign out_ch.found_triple    = out_ft_r;
  assign out_ch.found_pattern   = out_fp_r;

  // checks
  `CTC_CHECK_IMPLY(a_unc_bound, 1'b1, unc_r <= ctc_pkg::UNC_RESET)
  `CTC_CHECK_IMPLY(a_clear_empty, state_r == S_CLR, present_r == '0)
  `CTC_CHECK_IMPLY(a_idle_no_write, state_r == S_IDLE, !cnt_we)
  `CTC_CHECK_NEXT(a_store_marks, state_r == S_ROWRD && act_r == ctc_pkg::ACT_STORE, present_r[row_r])
endmodule
`default_nettype wire

### rtl/ctc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end
endmodule
`default_nettype wire
